[src/clcd_pkg.sv]
// Shared types, codes and constants of the character LCD command sequencer.
package clcd_pkg;

    // Request codes carried in the command field.
    localparam logic [2:0] CMD_INSTR  = 3'd0;
    localparam logic [2:0] CMD_CHAR   = 3'd1;
    localparam logic [2:0] CMD_POS    = 3'd2;
    localparam logic [2:0] CMD_NUMBER = 3'd3;
    localparam logic [2:0] CMD_INIT   = 3'd4;

    // Decimal printing limits and derived widths.
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int COL_W      = 7;

    // Bus bytes with a fixed meaning.
    localparam logic [7:0] INIT_FUNCTION_SET = 8'h38;
    localparam logic [7:0] INIT_DISPLAY_ON   = 8'b0000_1100;
    localparam logic [7:0] INIT_CLEAR        = 8'h01;
    localparam logic [7:0] ASCII_ZERO        = 8'd48;
    localparam logic [7:0] SET_DDRAM_ADDR    = 8'h80;
    localparam logic [6:0] ROW1_OFFSET_RESET = 7'd64;

    // Reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  byte_value;
        logic [31:0] number;
        logic        row;
        logic [5:0]  column;
    } req_t;

    typedef struct packed {
        logic       is_character;
        logic [7:0] bus_byte;
        logic       last;
    } wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSTR,
        ST_CHAR,
        ST_SETPOS,
        ST_INIT0,
        ST_INIT1,
        ST_INIT2,
        ST_MUL,
        ST_DIGIT,
        ST_DPOS,
        ST_DCHAR
    } state_t;

    // Source of the byte loaded into the output register.
    typedef enum logic [2:0] {
        SEL_RAW_INSTR,
        SEL_RAW_CHAR,
        SEL_POS,
        SEL_DIGIT,
        SEL_INIT_FUNC,
        SEL_INIT_DISP,
        SEL_INIT_CLEAR
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_step;
        logic     digit_step;
        logic     load_out;
        out_sel_t out_sel;
        logic     out_last;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
        logic digit_done;
        logic emit_last;
    } status_t;

endpackage

[src/clcd_ctrl.sv]
// Control state machine of the character LCD command sequencer.
module clcd_ctrl
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [2:0] command,
    input  status_t    status,
    output logic       ready,
    output state_t     state,
    output ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (command)
                        CMD_INSTR:  state_next = ST_INSTR;
                        CMD_CHAR:   state_next = ST_CHAR;
                        CMD_POS:    state_next = ST_SETPOS;
                        CMD_NUMBER: state_next = ST_MUL;
                        CMD_INIT:   state_next = ST_INIT0;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INSTR, ST_CHAR, ST_SETPOS, ST_INIT2:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INIT0:
            begin
                if (status.out_free)
                begin
                    state_next = ST_INIT1;
                end
            end
            ST_INIT1:
            begin
                if (status.out_free)
                begin
                    state_next = ST_INIT2;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                state_next = status.digit_done ? ST_DPOS : ST_MUL;
            end
            ST_DPOS:
            begin
                if (status.out_free)
                begin
                    state_next = ST_DCHAR;
                end
            end
            ST_DCHAR:
            begin
                if (status.out_free)
                begin
                    state_next = status.emit_last ? ST_IDLE : ST_DPOS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.out_sel    = SEL_RAW_INSTR;
        ready           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready        = 1'b1;
                ctrl.capture = req_valid;
            end
            ST_INSTR:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_RAW_INSTR;
                ctrl.out_last = 1'b1;
            end
            ST_CHAR:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_RAW_CHAR;
                ctrl.out_last = 1'b1;
            end
            ST_SETPOS:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_POS;
                ctrl.out_last = 1'b1;
            end
            ST_INIT0:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_INIT_FUNC;
            end
            ST_INIT1:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_INIT_DISP;
            end
            ST_INIT2:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_INIT_CLEAR;
                ctrl.out_last = 1'b1;
            end
            ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
            end
            ST_DIGIT:
            begin
                ctrl.digit_step = 1'b1;
            end
            ST_DPOS:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_POS;
            end
            ST_DCHAR:
            begin
                ctrl.load_out = status.out_free;
                ctrl.out_sel  = SEL_DIGIT;
                ctrl.out_last = status.emit_last;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

[src/clcd_datapath.sv]
// Datapath: request registers, decimal digit extraction and the output register.
module clcd_datapath
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  req_t       req,
    input  ctrl_t      ctrl,
    input  logic       wr_stall,
    output logic       wr_valid,
    output wr_t        wr,
    output status_t    status
);

    logic [6:0]        offset_reg;
    logic [7:0]        byte_reg;
    logic              row_reg;
    logic [5:0]        column_reg;
    logic [31:0]       value_reg;
    logic [63:0]       product_reg;
    logic [3:0]        digits_reg [MAX_DIGITS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [COL_W-1:0]  col_reg;
    logic              out_valid_reg;
    wr_t               out_reg;

    logic [31:0]       quotient;
    logic [3:0]        quotient_x10_low;
    logic [3:0]        remainder;
    logic [7:0]        address;
    logic [7:0]        pos_byte;
    wr_t               out_next;

    // Quotient by reciprocal multiply; the remainder is below ten, so four bits suffice.
    assign quotient         = 32'(product_reg >> RECIP_SHIFT);
    assign quotient_x10_low = quotient[3:0] * 4'd10;
    assign remainder        = value_reg[3:0] - quotient_x10_low;

    assign address  = row_reg ? ({1'b0, offset_reg} + {1'b0, col_reg}) : {1'b0, col_reg};
    assign pos_byte = SET_DDRAM_ADDR | address;

    assign status.out_free   = !out_valid_reg || !wr_stall;
    assign status.digit_done = (quotient == 32'd0) || (count_reg == CNT_W'(MAX_DIGITS - 1));
    assign status.emit_last  = ((idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        out_next.last         = ctrl.out_last;
        out_next.is_character = 1'b0;
        case (ctrl.out_sel)
            SEL_RAW_INSTR:  out_next.bus_byte = byte_reg;
            SEL_RAW_CHAR:
            begin
                out_next.bus_byte     = byte_reg;
                out_next.is_character = 1'b1;
            end
            SEL_POS:        out_next.bus_byte = pos_byte;
            SEL_DIGIT:
            begin
                out_next.bus_byte     = ASCII_ZERO + {4'd0, digits_reg[idx_reg[IDX_W-1:0]]};
                out_next.is_character = 1'b1;
            end
            SEL_INIT_FUNC:  out_next.bus_byte = INIT_FUNCTION_SET;
            SEL_INIT_DISP:  out_next.bus_byte = INIT_DISPLAY_ON;
            SEL_INIT_CLEAR: out_next.bus_byte = INIT_CLEAR;
            default:        out_next.bus_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= ROW1_OFFSET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!wr_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            byte_reg   <= req.byte_value;
            row_reg    <= req.row;
            column_reg <= req.column;
            value_reg  <= req.number;
            count_reg  <= '0;
            col_reg    <= {1'b0, req.column};
        end
        if (ctrl.mul_step)
        begin
            product_reg <= value_reg * RECIP_TEN;
        end
        if (ctrl.digit_step)
        begin
            digits_reg[count_reg[IDX_W-1:0]] <= remainder;
            value_reg <= quotient;
            count_reg <= count_reg + CNT_W'(1);
            if (status.digit_done)
            begin
                // Most significant digit lands at the given column.
                col_reg <= {1'b0, column_reg} + COL_W'(count_reg);
                idx_reg <= '0;
            end
        end
        if (ctrl.load_out && ctrl.out_sel == SEL_DIGIT)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            col_reg <= col_reg - COL_W'(1);
        end
        if (ctrl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign wr_valid = out_valid_reg;
    assign wr       = out_reg;

endmodule

[src/char_lcd_command_sequencer.sv]
// Sequence: a raw, position or init request loads its first bus write into the output
// register once that register is free; a number is first split into decimal digits, one
// pass through the multiply and digit states per digit, then emits one write per cycle
// while the receiver does not stall (up to 20 writes). Throughput: one request at a time,
// set by the shared divide-by-ten step and the single output register.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to idle, empties
// the output register and sets the second-row offset to 64.
module char_lcd_command_sequencer
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       wr_valid,
    input  logic       wr_stall,
    output wr_t        wr
);

    logic    ready;
    state_t  state;
    ctrl_t   ctrl;
    status_t status;

    // The controller walks each request through its writes. A number first runs
    // through the divide-by-ten loop, one digit per ST_MUL to ST_DIGIT pass, with
    // the digits collected least significant first; then each digit is sent as a
    // position write followed by its ASCII character, walking the column leftward.
    clcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .command   (req.command),
        .status    (status),
        .ready     (ready),
        .state     (state),
        .ctrl      (ctrl)
    );

    // The datapath holds the request, the configuration register, the digit store
    // and the output register that decouples the LCD side from the sequencer.
    clcd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .ctrl      (ctrl),
        .wr_stall  (wr_stall),
        .wr_valid  (wr_valid),
        .wr        (wr),
        .status    (status)
    );

    // A new request transfer is taken only while the sequencer is idle.
    assign req_stall = !ready;

    // A pending bus write is never overwritten before its transfer.
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> status.out_free)
        else $error("output register loaded while a write was pending");

    // A number request enters the digit loop right after its transfer.
    a_number_start : assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.command == CMD_NUMBER) |=> state == ST_MUL)
        else $error("number request did not start the digit loop");

    // No bus write is produced while idle.
    a_idle_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_IDLE) |-> !ctrl.load_out)
        else $error("bus write loaded while idle");

endmodule

[tb/sv/clcd_write_checker.sv]
// Checker for the LCD command sequencer: predicts the bus writes of each request and compares them.
`timescale 1ns / 1ps
module clcd_write_checker
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       req_valid,
    input  logic       req_stall,
    input  req_t       req,
    input  logic       wr_valid,
    input  logic       wr_stall,
    input  wr_t        wr,
    output int         fail_count,
    output int         outstanding
);

    localparam int REPORT_LIMIT = 10;

    logic [6:0] row1_offset;
    wr_t        pending_writes[$];

    function automatic wr_t bus_write(input logic is_char, input logic [7:0] value);
        wr_t w;
        w.is_character = is_char;
        w.bus_byte     = value;
        w.last         = 1'b0;
        return w;
    endfunction

    // Set-address byte; the row-1 address wraps to 8 bits before the command bit is set.
    function automatic logic [7:0] position_byte(input logic row_sel, input int col);
        logic [7:0] addr;
        addr = row_sel ? 8'(int'(row1_offset) + col) : 8'(col);
        return addr | SET_DDRAM_ADDR;
    endfunction

    // Appends every write that one request causes, last flag on the final one.
    function automatic void queue_bus_writes(input req_t r);
        wr_t         batch[$];
        logic [31:0] value;
        logic [3:0]  digits[MAX_DIGITS];
        int          count;
        count = 0;
        case (r.command)
            CMD_INSTR: batch.push_back(bus_write(1'b0, r.byte_value));
            CMD_CHAR:  batch.push_back(bus_write(1'b1, r.byte_value));
            CMD_POS:   batch.push_back(bus_write(1'b0, position_byte(r.row, int'(r.column))));
            CMD_NUMBER:
            begin
                value = r.number;
                do
                begin
                    digits[count] = 4'(value % 10);
                    count++;
                    value = value / 10;
                end
                while (value != 0 && count < MAX_DIGITS);
                // Least significant digit first, placed at the rightmost column.
                for (int i = 0; i < count; i++)
                begin
                    batch.push_back(bus_write(1'b0,
                        position_byte(r.row, int'(r.column) + count - 1 - i)));
                    batch.push_back(bus_write(1'b1, ASCII_ZERO + 8'(digits[i])));
                end
            end
            CMD_INIT:
            begin
                batch.push_back(bus_write(1'b0, INIT_FUNCTION_SET));
                batch.push_back(bus_write(1'b0, INIT_DISPLAY_ON));
                batch.push_back(bus_write(1'b0, INIT_CLEAR));
            end
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pending_writes.push_back(batch[k]);
    endfunction

    always @(posedge clk)
    begin
        wr_t want;
        if (!rst_n)
        begin
            row1_offset = ROW1_OFFSET_RESET;
            pending_writes.delete();
        end
        else
        begin
            // Results are taken first: a request accepted at this edge cannot own one yet.
            if (wr_valid && !wr_stall)
            begin
                if (pending_writes.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected bus write: is_character=%0b bus_byte=%02h last=%0b",
                                 wr.is_character, wr.bus_byte, wr.last);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (wr.is_character !== want.is_character || wr.bus_byte !== want.bus_byte
                        || wr.last !== want.last)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT)
                            $display("bus write mismatch: expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                                     want.is_character, want.bus_byte, want.last,
                                     wr.is_character, wr.bus_byte, wr.last);
                    end
                end
            end
            if (cfg_we)
                row1_offset = cfg_wdata;
            if (req_valid && !req_stall)
                queue_bus_writes(req);
        end
        outstanding = pending_writes.size();
    end

endmodule

[tb/sv/tb.sv]
// Testbench top: drives requests and offset writes into the LCD command sequencer, gives the verdict.
`timescale 1ns / 1ps
module tb;
    import clcd_pkg::*;

    // The longest quiet stretch of a correct run is a ten-digit split plus a long stall run;
    // this limit is many times that.
    localparam int IDLE_LIMIT    = 5000;
    // A request the block ignores does not keep it busy; a full number is the longest request.
    localparam int SETTLE_CYCLES = 60;
    localparam int SEGMENT_ITEMS = 30;
    localparam int SEGMENTS      = 6;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    logic       req_valid;
    logic       req_stall;
    req_t       req;
    logic       wr_valid;
    logic       wr_stall;
    wr_t        wr;

    logic req_took = 1'b0;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   idle_cycles;
    int   fail_count;
    int   outstanding;

    char_lcd_command_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr        (wr)
    );

    clcd_write_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .wr_valid    (wr_valid),
        .wr_stall    (wr_stall),
        .wr          (wr),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Acceptance is sampled at the rising edge so the falling-edge driver sees a settled value.
    // The same block runs the watchdog on cycles that move no transfer on either channel.
    always @(posedge clk)
    begin
        req_took <= req_valid && !req_stall;
        if ((req_valid && !req_stall) || (wr_valid && !wr_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver stalls at random, independently of whether a write is offered.
    always @(negedge clk)
    begin
        if (!rst_n)
            wr_stall <= 1'b0;
        else
            wr_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic req_t make_req(input logic [2:0] cmd, input logic [7:0] value,
                                      input logic [31:0] num, input logic row_sel,
                                      input logic [5:0] col);
        req_t r;
        r.command    = cmd;
        r.byte_value = value;
        r.number     = num;
        r.row        = row_sel;
        r.column     = col;
        return r;
    endfunction

    // Mostly well-formed requests, with numbers spread evenly over their digit counts so that
    // short and long splits both occur; a few requests use the unused codes.
    function automatic req_t random_req();
        req_t        r;
        int          pick;
        int          digit_count;
        int unsigned lo;
        int unsigned hi;
        r.byte_value = 8'($urandom);
        r.number     = $urandom;
        r.row        = 1'($urandom);
        r.column     = 6'($urandom);
        pick = $urandom_range(99);
        if (pick < 5)
            r.command = CMD_INIT + 3'($urandom_range(3, 1));
        else if (pick < 20)
            r.command = CMD_INSTR;
        else if (pick < 35)
            r.command = CMD_CHAR;
        else if (pick < 55)
            r.command = CMD_POS;
        else if (pick < 90)
            r.command = CMD_NUMBER;
        else
            r.command = CMD_INIT;
        if (r.command == CMD_NUMBER && $urandom_range(3) != 0)
        begin
            digit_count = $urandom_range(MAX_DIGITS, 1);
            lo = 1;
            repeat (digit_count - 1) lo = lo * 10;
            hi = (digit_count == MAX_DIGITS) ? 32'hFFFF_FFFF : lo * 10 - 1;
            if (digit_count == 1)
                lo = 0;
            r.number = $urandom_range(hi, lo);
        end
        return r;
    endfunction

    // Offers one request, with random idle cycles ahead of it, and returns at the falling edge
    // after its transfer. The caller then either offers the next one or drops valid.
    task automatic send_req(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(negedge clk);
        while (!req_took)
            @(negedge clk);
    endtask

    // Waits until every predicted write has arrived and the block has had time to go idle.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_offset(input logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        req_t       directed[$];
        req_t       item;
        logic [6:0] offsets[SEGMENTS];
        int         sent;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_valid      = 1'b0;
        req            = '0;
        send_idle_pct  = 29;
        recv_stall_pct = 56;

        offsets[0] = 7'd0;
        offsets[1] = 7'd127;
        offsets[2] = 7'($urandom);
        offsets[3] = 7'd1;
        offsets[4] = 7'($urandom);
        offsets[5] = ROW1_OFFSET_RESET;

        // Directed requests run with the reset offset: byte extremes, both rows at the
        // column extremes, zero, the largest value, digit-count boundaries and unused codes.
        directed.push_back(make_req(CMD_INIT,   8'h00, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_INSTR,  INIT_CLEAR, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_INSTR,  8'h00, 32'hFFFF_FFFF, 1'b1, 6'd63));
        directed.push_back(make_req(CMD_INSTR,  8'hFF, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_CHAR,   8'h00, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_CHAR,   8'hFF, 32'd0, 1'b1, 6'd63));
        directed.push_back(make_req(CMD_CHAR,   8'h41, 32'd0, 1'b0, 6'd5));
        directed.push_back(make_req(CMD_POS,    8'h00, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_POS,    8'h00, 32'd0, 1'b0, 6'd63));
        directed.push_back(make_req(CMD_POS,    8'h00, 32'd0, 1'b1, 6'd0));
        directed.push_back(make_req(CMD_POS,    8'h00, 32'd0, 1'b1, 6'd63));
        directed.push_back(make_req(CMD_NUMBER, 8'h00, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_NUMBER, 8'h00, 32'd0, 1'b1, 6'd63));
        directed.push_back(make_req(CMD_NUMBER, 8'h00, 32'd9, 1'b0, 6'd10));
        directed.push_back(make_req(CMD_NUMBER, 8'h00, 32'd10, 1'b1, 6'd3));
        directed.push_back(make_req(CMD_NUMBER, 8'h00, 32'd999_999_999, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_NUMBER, 8'h00, 32'd1_000_000_000, 1'b1, 6'd30));
        directed.push_back(make_req(CMD_NUMBER, 8'hFF, 32'hFFFF_FFFF, 1'b1, 6'd63));
        directed.push_back(make_req(CMD_INIT + 3'd1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 6'd63));
        directed.push_back(make_req(CMD_INIT + 3'd2, 8'h00, 32'd0, 1'b0, 6'd0));
        directed.push_back(make_req(CMD_INIT + 3'd3, 8'h5A, 32'd12345, 1'b1, 6'd20));
        directed.push_back(make_req(CMD_INIT,   8'hFF, 32'hFFFF_FFFF, 1'b1, 6'd63));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_req(directed[i]);
        drain();

        // Two segments with a slow receiver, two with a slow sender, two at full speed,
        // each starting with a fresh row-1 offset while the block is idle.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 2)
            begin
                send_idle_pct  = 29;
                recv_stall_pct = 56;
            end
            else if (seg < 4)
            begin
                send_idle_pct  = 56;
                recv_stall_pct = 29;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_offset(offsets[seg]);
            sent = 0;
            while (sent < SEGMENT_ITEMS)
            begin
                item = random_req();
                send_req(item);
                if (item.command <= CMD_INIT)
                    sent++;
            end
            drain();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
src/clcd_pkg.sv
src/clcd_ctrl.sv
src/clcd_datapath.sv
src/char_lcd_command_sequencer.sv
tb/sv/clcd_write_checker.sv
tb/sv/tb.sv
